// File: src/ttc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the temperature trend classifier.
// No dependencies.
package ttc_pkg;

    localparam int WINDOW_LENGTH = 6;
    localparam int HALF_LENGTH   = WINDOW_LENGTH / 2;

    localparam int SAMPLE_W = 14;
    localparam int THR_W    = 10;
    localparam int HSD_W    = 17;
    localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);

    localparam int DIFF_RAW_W = SAMPLE_W + $clog2(HALF_LENGTH + 1) + 1;
    localparam int DIFF_W     = (DIFF_RAW_W > HSD_W) ? DIFF_RAW_W : HSD_W;

    localparam int SAMPLE_MIN = -4000;
    localparam int SAMPLE_MAX = 8000;
    localparam int HSD_MIN    = -(2 ** (HSD_W - 1));
    localparam int HSD_MAX    = (2 ** (HSD_W - 1)) - 1;

    localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(20);
    localparam logic [CNT_W-1:0]  WINDOW_COUNT  = CNT_W'(WINDOW_LENGTH);
    localparam logic [DIFF_W-1:0] HALF_MULT     = DIFF_W'(HALF_LENGTH);

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef sample_t [WINDOW_LENGTH-1:0] window_t;

    typedef enum logic [1:0] {
        TREND_STABLE  = 2'd0,
        TREND_WARMING = 2'd1,
        TREND_COOLING = 2'd2
    } trend_t;

    typedef struct packed {
        logic valid;
        logic full;
    } win_stat_t;

endpackage

// File: src/ttc_window.sv
`timescale 1ns / 1ps
// Input stage: sample clamp, sliding sample window and fill count.
// Depends on ttc_pkg.
module ttc_window (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ttc_pkg::sample_t in_sample,
    output ttc_pkg::win_stat_t st_stat,
    input  logic            st_ready,
    output ttc_pkg::window_t st_window
);
    import ttc_pkg::*;

    localparam sample_t LIM_LO = SAMPLE_W'(SAMPLE_MIN);
    localparam sample_t LIM_HI = SAMPLE_W'(SAMPLE_MAX);

    logic             st_valid_reg;
    logic [CNT_W-1:0] fill_count_reg;
    logic [CNT_W-1:0] fill_count_next;
    window_t          window_reg;
    window_t          window_next;
    sample_t          clamped;
    logic             accept;
    logic             is_full;

    assign in_ready = !st_valid_reg || st_ready;
    assign accept   = in_valid && in_ready;
    assign is_full  = (fill_count_reg == WINDOW_COUNT);

    always_comb begin
        if (in_sample < LIM_LO) begin
            clamped = LIM_LO;
        end else if (in_sample > LIM_HI) begin
            clamped = LIM_HI;
        end else begin
            clamped = in_sample;
        end
    end

    always_comb begin
        window_next     = window_reg;
        fill_count_next = fill_count_reg;
        if (!is_full) begin
            fill_count_next = fill_count_reg + CNT_W'(1);
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                if (fill_count_reg == CNT_W'(i)) begin
                    window_next[i] = clamped;
                end
            end
        end else begin
            for (int i = 0; i < WINDOW_LENGTH - 1; i++) begin
                window_next[i] = window_reg[i + 1];
            end
            window_next[WINDOW_LENGTH-1] = clamped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg   <= 1'b0;
            fill_count_reg <= '0;
        end else begin
            if (in_ready) begin
                st_valid_reg <= in_valid;
            end
            if (accept) begin
                fill_count_reg <= fill_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            window_reg <= window_next;
        end
    end

    assign st_stat.valid = st_valid_reg;
    assign st_stat.full  = is_full;
    assign st_window     = window_reg;

    a_fill_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_count_reg <= WINDOW_COUNT)
        else $error("fill count beyond window length");

    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_full) |=> fill_count_reg == CNT_W'($past(fill_count_reg) + CNT_W'(1)))
        else $error("fill count did not advance on transfer");

    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        is_full |=> is_full)
        else $error("window full dropped");

endmodule

// File: src/ttc_classify.sv
`timescale 1ns / 1ps
// Half-sum difference, saturation, trend compare and result register.
// Depends on ttc_pkg.
module ttc_classify (
    input  logic               aclk,
    input  logic               aresetn,
    input  ttc_pkg::win_stat_t st_stat,
    output logic               st_ready,
    input  ttc_pkg::window_t   st_window,
    input  logic [ttc_pkg::THR_W-1:0] threshold,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_window_full,
    output logic signed [ttc_pkg::HSD_W-1:0] m_half_sum_difference,
    output logic [1:0]         m_trend_code
);
    import ttc_pkg::*;

    localparam logic signed [DIFF_W-1:0] SAT_LO = DIFF_W'(HSD_MIN);
    localparam logic signed [DIFF_W-1:0] SAT_HI = DIFF_W'(HSD_MAX);

    logic                       m_valid_reg;
    logic                       full_reg;
    logic signed [HSD_W-1:0]    hsd_reg;
    trend_t                     trend_reg;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [DIFF_W-1:0]   bound;
    logic signed [DIFF_W-1:0]   shown;
    trend_t                     trend_next;
    logic                       load;

    assign st_ready = !m_valid_reg || m_ready;
    assign load     = st_stat.valid && st_ready;

    always_comb begin
        diff = '0;
        if (st_stat.full) begin
            for (int i = 0; i < HALF_LENGTH; i++) begin
                diff = diff + DIFF_W'(st_window[WINDOW_LENGTH - HALF_LENGTH + i])
                            - DIFF_W'(st_window[i]);
            end
        end
    end

    assign bound = $signed(DIFF_W'(threshold) * HALF_MULT);

    always_comb begin
        trend_next = TREND_STABLE;
        if (st_stat.full) begin
            if (diff <= -bound) begin
                trend_next = TREND_COOLING;
            end else if (diff >= bound) begin
                trend_next = TREND_WARMING;
            end
        end
    end

    always_comb begin
        if (diff < SAT_LO) begin
            shown = SAT_LO;
        end else if (diff > SAT_HI) begin
            shown = SAT_HI;
        end else begin
            shown = diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_ready) begin
            m_valid_reg <= st_stat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            full_reg  <= st_stat.full;
            hsd_reg   <= HSD_W'(shown);
            trend_reg <= trend_next;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_window_full         = full_reg;
    assign m_half_sum_difference = hsd_reg;
    assign m_trend_code          = trend_reg;

    a_not_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !full_reg) |-> (hsd_reg == '0 && trend_reg == TREND_STABLE))
        else $error("result fields set before window full");

    a_load_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule

// File: src/temperature_trend_classifier_top.sv
`timescale 1ns / 1ps
// An input transfer is registered in the window stage, then in the result register,
// where the result is presented. Throughput: one sample per cycle; a held result
// stalls the input through the window stage and the result register.
// Reset (aresetn low, synchronous): fill count cleared, threshold set to 20,
// no result pending. Depends on ttc_pkg, ttc_window, ttc_classify.
module temperature_trend_classifier_top (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic [ttc_pkg::THR_W-1:0] cfg_trend_threshold,
    input  logic s_valid,
    output logic s_ready,
    input  logic signed [ttc_pkg::SAMPLE_W-1:0] s_temperature_sample,
    output logic m_valid,
    input  logic m_ready,
    output logic m_window_full,
    output logic signed [ttc_pkg::HSD_W-1:0] m_half_sum_difference,
    output logic [1:0] m_trend_code
);
    import ttc_pkg::*;

    logic [THR_W-1:0] threshold_reg;
    win_stat_t        st_stat;
    logic             st_ready;
    window_t          st_window;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RST;
        end else if (cfg_valid) begin
            threshold_reg <= cfg_trend_threshold;
        end
    end

    ttc_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_temperature_sample),
        .st_stat   (st_stat),
        .st_ready  (st_ready),
        .st_window (st_window)
    );

    ttc_classify u_classify (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .st_stat               (st_stat),
        .st_ready              (st_ready),
        .st_window             (st_window),
        .threshold             (threshold_reg),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_window_full         (m_window_full),
        .m_half_sum_difference (m_half_sum_difference),
        .m_trend_code          (m_trend_code)
    );

endmodule
